/* design/rmm_pkg.sv */
// Package for the radar measurement model: constants, types and the arctangent table.
`default_nettype none
package rmm_pkg;
    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629713;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [31:0] GAIN_INV_Q30 = 32'sd652032874;

    // Datapath widths
    localparam int VW = 64;   // vectoring / rotation x, y
    localparam int ZW = 34;   // angle accumulators
    localparam int SQW = 66;  // sum of squares and remainder
    localparam int NW = 96;   // divider numerator
    localparam int DW = 34;   // divider denominator

    typedef logic signed [VW-1:0] vec_t;
    typedef logic signed [ZW-1:0] ang_t;

    // Per-point sideband that rides along every chain
    typedef struct packed {
        logic                valid;
        logic                last;
        logic signed [31:0]  pos_x;
        logic signed [31:0]  pos_y;
        logic signed [31:0]  speed;
        logic                y_zero;
        logic                x_neg;
        logic                flip;
    } tag_t;

    function automatic ang_t atan_q28(input int i);
        ang_t r;
        r = '0;
        unique case (i)
            0: r = 34'sd210828714;
            1: r = 34'sd124459457;
            2: r = 34'sd65760959;
            3: r = 34'sd33381290;
            4: r = 34'sd16755422;
            5: r = 34'sd8385879;
            6: r = 34'sd4193963;
            7: r = 34'sd2097109;
            8: r = 34'sd1048571;
            9: r = 34'sd524287;
            10: r = 34'sd262144;
            default: r = (i <= 28) ? (ang_t'(1) <<< (28 - i)) : '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

/* design/radar_measurement_model.sv */
// Top level of the radar measurement model: pipelined CORDICs, square root and divider.
//
// channel   | ports                                          | transfer
// ----------+------------------------------------------------+--------------------------
// config    | range_floor_we, range_floor_wdata[15:0]        | edge with range_floor_we
// point in  | start, busy, pos_x, pos_y, speed, heading,     | edge with start & !busy
//           | last_in                                        |
// result    | done, range_out, bearing, range_rate, last_out | the one cycle done is high
//
// One point is taken every cycle; busy is tied low. The path is:
// 1 prep stage, then the longer of CORDIC_STAGES (at most 32) rotation cells plus 3
// projection/multiply stages and the 32 square-root cells (the shorter side
// is delayed to match), then 64 divider cells and one output stage.
// Reset clears the valid chain and sets range_floor to 1.
// The receiver cannot stall, so nothing backs up.
`default_nettype none
module radar_measurement_model #(
    parameter int CORDIC_STAGES = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               range_floor_we,
    input  wire logic [15:0]        range_floor_wdata,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] speed,
    input  wire logic signed [31:0] heading,
    input  wire logic               last_in,
    output logic                    done,
    output logic [31:0]             range_out,
    output logic signed [30:0]      bearing,
    output logic signed [31:0]      range_rate,
    output logic                    last_out
);
    import rmm_pkg::*;

    localparam int NS = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
    localparam int SQ_N = 32;
    localparam int DV_N = 64;
    // numerator is ready after the CORDIC cells and the projection stages, range after the square-root cells
    localparam int P_LAT = NS + 3;
    localparam int DV_AT = (P_LAT > SQ_N) ? P_LAT : SQ_N;
    localparam int NUM_DLY = DV_AT - P_LAT;
    localparam int RNG_DLY = DV_AT - SQ_N;

    logic [15:0] range_floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            range_floor_reg <= 16'd1;
        else if (range_floor_we)
            range_floor_reg <= range_floor_wdata;
    end

    assign busy = 1'b0;

    // ---------------- prep stage: heading reduction, vector set-up, squares
    logic        acc;
    logic signed [33:0] h0, h1, h2;
    logic        flip0;
    tag_t        tag_next, tag_reg;
    vec_t        vx_reg, vy_reg, rx_reg, ry_reg;
    ang_t        vz_reg, rz_reg;
    vec_t        vx_next, vy_next;
    ang_t        vz_next;
    logic [SQW-1:0] sq_reg, sq_next;
    logic [31:0] ax, ay;

    assign acc = start;

    always_comb
    begin
        // a 32-bit heading needs at most two 2pi steps
        h0 = 34'(heading);
        h1 = h0;
        if (h1 > 34'(PI_Q28))
            h1 = h1 - 34'(TWO_PI_Q28);
        else if (h1 <= -34'(PI_Q28))
            h1 = h1 + 34'(TWO_PI_Q28);
        h2 = h1;
        if (h2 > 34'(PI_Q28))
            h2 = h2 - 34'(TWO_PI_Q28);
        else if (h2 <= -34'(PI_Q28))
            h2 = h2 + 34'(TWO_PI_Q28);
        flip0 = 1'b0;
        if (h2 > 34'(HALF_PI_Q28))
        begin
            h2 = h2 - 34'(PI_Q28);
            flip0 = 1'b1;
        end
        else if (h2 < -34'(HALF_PI_Q28))
        begin
            h2 = h2 + 34'(PI_Q28);
            flip0 = 1'b1;
        end

        tag_next.valid  = acc;
        tag_next.last   = last_in;
        tag_next.pos_x  = pos_x;
        tag_next.pos_y  = pos_y;
        tag_next.speed  = speed;
        tag_next.y_zero = (pos_y == 32'sd0);
        tag_next.x_neg  = pos_x[31];
        tag_next.flip   = flip0;

        vz_next = '0;
        vx_next = VW'(pos_x) <<< 29;
        vy_next = VW'(pos_y) <<< 29;
        if (pos_x[31])
        begin
            vz_next = (pos_y > 0) ? ZW'(PI_Q28) : -ZW'(PI_Q28);
            vx_next = -(VW'(pos_x) <<< 29);
            vy_next = -(VW'(pos_y) <<< 29);
        end

        ax = pos_x[31] ? 32'(-pos_x) : 32'(pos_x);
        ay = pos_y[31] ? 32'(-pos_y) : 32'(pos_y);
        sq_next = SQW'(64'(ax) * 64'(ax)) + SQW'(64'(ay) * 64'(ay));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '0;
        else
            tag_reg <= tag_next;
    end

    always_ff @(posedge clk)
    begin
        vx_reg <= vx_next;
        vy_reg <= vy_next;
        vz_reg <= vz_next;
        rx_reg <= VW'(GAIN_INV_Q30);
        ry_reg <= '0;
        rz_reg <= ZW'(h2);
        sq_reg <= sq_next;
    end

    // ---------------- CORDIC chains
    vec_t vx [0:NS];
    vec_t vy [0:NS];
    ang_t vz [0:NS];
    vec_t rx [0:NS];
    vec_t ry [0:NS];
    ang_t rz [0:NS];
    logic vv [0:NS];
    logic rv [0:NS];

    assign vx[0] = vx_reg;
    assign vy[0] = vy_reg;
    assign vz[0] = vz_reg;
    assign rx[0] = rx_reg;
    assign ry[0] = ry_reg;
    assign rz[0] = rz_reg;
    assign vv[0] = tag_reg.valid;
    assign rv[0] = tag_reg.valid;

    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        rmm_cordic_cell #(.STAGE(i), .VECTORING(1'b1)) u_vec (
            .clk(clk), .rst_n(rst_n), .in_valid(vv[i]),
            .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
            .out_valid(vv[i+1]), .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1]));
        rmm_cordic_cell #(.STAGE(i), .VECTORING(1'b0)) u_rot (
            .clk(clk), .rst_n(rst_n), .in_valid(rv[i]),
            .x_in(rx[i]), .y_in(ry[i]), .z_in(rz[i]),
            .out_valid(rv[i+1]), .x_out(rx[i+1]), .y_out(ry[i+1]), .z_out(rz[i+1]));
    end

    // ---------------- square root chain (32 cells, starts after prep)
    logic [SQW-1:0] sv [0:SQ_N];
    logic [SQW-1:0] sr [0:SQ_N];
    assign sv[0] = sq_reg;
    assign sr[0] = '0;
    for (genvar i = 0; i < SQ_N; i++)
    begin : g_sqrt
        rmm_sqrt_cell #(.STAGE(i)) u_sq (
            .clk(clk), .v_in(sv[i]), .r_in(sr[i]), .v_out(sv[i+1]), .r_out(sr[i+1]));
    end

    // ---------------- sideband delay line up to the divider entry
    tag_t tg [0:DV_AT];
    assign tg[0] = tag_reg;
    for (genvar i = 0; i < DV_AT; i++)
    begin : g_tag
        tag_t t_reg;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                t_reg <= '0;
            else
                t_reg <= tg[i];
        end
        assign tg[i+1] = t_reg;
    end

    // bearing clamp right after the vectoring CORDIC
    logic signed [30:0] brg_c;
    always_comb
    begin
        if (tg[NS].y_zero)
            brg_c = tg[NS].x_neg ? 31'(PI_Q28) : 31'sd0;
        else if (vz[NS] > ZW'(PI_Q28))
            brg_c = 31'(PI_Q28);
        else if (vz[NS] <= -ZW'(PI_Q28))
            brg_c = 31'(-PI_Q28 + 32'sd1);
        else
            brg_c = 31'(vz[NS]);
    end

    // square root result after its chain, with rounding
    logic [31:0] rng_c;
    assign rng_c = (sv[SQ_N] > sr[SQ_N]) ? 32'(sr[SQ_N] + 1'b1) : 32'(sr[SQ_N]);

    // ---------------- projection: two products, sum, round, times speed
    logic signed [31:0] cs_c, sn_c;
    logic signed [63:0] px_reg, py_reg;
    logic signed [47:0] proj_reg;
    logic signed [79:0] num_reg;
    logic signed [64:0] psum;

    assign cs_c = tg[NS].flip ? 32'(-rx[NS]) : 32'(rx[NS]);
    assign sn_c = tg[NS].flip ? 32'(-ry[NS]) : 32'(ry[NS]);
    assign psum = 65'(px_reg) + 65'(py_reg) + (65'sd1 <<< 29);

    always_ff @(posedge clk)
    begin
        px_reg   <= 64'(tg[NS].pos_x) * 64'(cs_c);
        py_reg   <= 64'(tg[NS].pos_y) * 64'(sn_c);
        proj_reg <= 48'(psum >>> 30);
        num_reg  <= 80'(tg[NS+2].speed) * 80'(proj_reg);
    end

    // numerator waits for the square root when that is the longer path
    logic signed [79:0] nm [0:NUM_DLY];
    assign nm[0] = num_reg;
    for (genvar i = 0; i < NUM_DLY; i++)
    begin : g_num
        logic signed [79:0] n_reg;
        always_ff @(posedge clk)
        begin
            n_reg <= nm[i];
        end
        assign nm[i+1] = n_reg;
    end

    // bearing follows the projection stages to the divider
    logic signed [30:0] brg_d [0:3+NUM_DLY];
    assign brg_d[0] = brg_c;
    for (genvar k = 0; k < 3 + NUM_DLY; k++)
    begin : g_side
        logic signed [30:0] b_reg;
        always_ff @(posedge clk)
        begin
            b_reg <= brg_d[k];
        end
        assign brg_d[k+1] = b_reg;
    end

    // range waits for the CORDIC side when that is the longer path
    logic [31:0] rl [0:RNG_DLY];
    assign rl[0] = rng_c;
    for (genvar i = 0; i < RNG_DLY; i++)
    begin : g_rl
        logic [31:0] r_reg;
        always_ff @(posedge clk)
        begin
            r_reg <= rl[i];
        end
        assign rl[i+1] = r_reg;
    end

    // ---------------- divider on magnitudes
    logic [NW-1:0] dv_rem [0:DV_N];
    logic [NW-1:0] dv_q   [0:DV_N];
    logic [DW-1:0] dv_den [0:DV_N];
    logic [NW-1:0] numabs;
    logic [DW-1:0] den_c;
    logic [31:0]   rng_div;
    tag_t          td [0:DV_N];
    logic          sg [0:DV_N];
    logic signed [30:0] bd [0:DV_N];
    logic [31:0]        rd [0:DV_N];

    assign rng_div = rl[RNG_DLY];
    assign numabs = nm[NUM_DLY][79] ? NW'(-nm[NUM_DLY]) : NW'(nm[NUM_DLY]);
    assign den_c  = DW'(rng_div) + DW'(range_floor_reg);
    assign dv_rem[0] = numabs;
    assign dv_q[0]   = '0;
    assign dv_den[0] = den_c;
    assign td[0] = tg[DV_AT];
    assign sg[0] = nm[NUM_DLY][79];
    assign bd[0] = brg_d[3+NUM_DLY];
    assign rd[0] = rng_div;

    for (genvar i = 0; i < DV_N; i++)
    begin : g_div
        rmm_div_cell #(.STAGE(i)) u_dv (
            .clk(clk), .rem_in(dv_rem[i]), .q_in(dv_q[i]), .den_in(dv_den[i]),
            .rem_out(dv_rem[i+1]), .q_out(dv_q[i+1]), .den_out(dv_den[i+1]));
        tag_t t_reg;
        logic s_reg;
        logic signed [30:0] b_reg;
        logic [31:0] r_reg;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                t_reg <= '0;
            else
                t_reg <= td[i];
        end
        always_ff @(posedge clk)
        begin
            s_reg <= sg[i];
            b_reg <= bd[i];
            r_reg <= rd[i];
        end
        assign td[i+1] = t_reg;
        assign sg[i+1] = s_reg;
        assign bd[i+1] = b_reg;
        assign rd[i+1] = r_reg;
    end

    // ---------------- saturation and output register
    logic signed [31:0] rr_c;
    logic [NW-1:0]      qa;
    always_comb
    begin
        qa = dv_q[DV_N];
        if (dv_den[DV_N] == '0)
            rr_c = 32'sd0;
        else if (!sg[DV_N])
            rr_c = (qa > NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(qa);
        else
            rr_c = (qa > NW'(33'h0_8000_0000)) ? 32'sh8000_0000 : 32'(-qa);
    end

    logic done_reg, last_reg;
    logic [31:0] range_reg;
    logic signed [30:0] bearing_reg;
    logic signed [31:0] rr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= td[DV_N].valid;
    end

    always_ff @(posedge clk)
    begin
        last_reg    <= td[DV_N].last;
        range_reg   <= rd[DV_N];
        bearing_reg <= bd[DV_N];
        rr_reg      <= rr_c;
    end

    assign done       = done_reg;
    assign last_out   = last_reg;
    assign range_out  = range_reg;
    assign bearing    = bearing_reg;
    assign range_rate = rr_reg;
endmodule
`default_nettype wire

/* design/rmm_cordic_cell.sv */
// One CORDIC micro-rotation cell, vectoring or rotation mode, with registered outputs.
`default_nettype none
module rmm_cordic_cell #(
    parameter int STAGE     = 0,
    parameter bit VECTORING = 1'b1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire rmm_pkg::vec_t x_in,
    input  wire rmm_pkg::vec_t y_in,
    input  wire rmm_pkg::ang_t z_in,
    output logic               out_valid,
    output rmm_pkg::vec_t      x_out,
    output rmm_pkg::vec_t      y_out,
    output rmm_pkg::ang_t      z_out
);
    import rmm_pkg::*;

    logic  dir_pos;
    vec_t  dx, dy, x_next, y_next;
    ang_t  z_next;
    logic  valid_reg;
    vec_t  x_reg, y_reg;
    ang_t  z_reg;

    always_comb
    begin
        // dx moves x, dy moves y
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        // vectoring drives y to zero, rotation drives z to zero
        dir_pos = VECTORING ? (y_in >= 0) : (z_in >= 0);
        if (VECTORING)
        begin
            x_next = dir_pos ? x_in + dx : x_in - dx;
            y_next = dir_pos ? y_in - dy : y_in + dy;
            z_next = dir_pos ? z_in + atan_q28(STAGE) : z_in - atan_q28(STAGE);
        end
        else
        begin
            x_next = dir_pos ? x_in - dx : x_in + dx;
            y_next = dir_pos ? y_in + dy : y_in - dy;
            z_next = dir_pos ? z_in - atan_q28(STAGE) : z_in + atan_q28(STAGE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign out_valid = valid_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule
`default_nettype wire

/* design/rmm_sqrt_cell.sv */
// One restoring square-root cell: retires one result bit per stage.
`default_nettype none
module rmm_sqrt_cell #(
    parameter int STAGE = 0
) (
    input  wire logic              clk,
    input  wire logic [rmm_pkg::SQW-1:0] v_in,
    input  wire logic [rmm_pkg::SQW-1:0] r_in,
    output logic [rmm_pkg::SQW-1:0]      v_out,
    output logic [rmm_pkg::SQW-1:0]      r_out
);
    import rmm_pkg::*;

    localparam logic [SQW-1:0] BIT = SQW'(1) << (62 - 2 * STAGE);

    logic [SQW-1:0] v_reg, r_reg, v_next, r_next;

    always_comb
    begin
        if (v_in >= r_in + BIT)
        begin
            v_next = v_in - (r_in + BIT);
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        r_reg <= r_next;
    end

    assign v_out = v_reg;
    assign r_out = r_reg;
endmodule
`default_nettype wire

/* design/rmm_div_cell.sv */
// One restoring divider cell: retires one quotient bit per stage.
`default_nettype none
module rmm_div_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                    clk,
    input  wire logic [rmm_pkg::NW-1:0]  rem_in,
    input  wire logic [rmm_pkg::NW-1:0]  q_in,
    input  wire logic [rmm_pkg::DW-1:0]  den_in,
    output logic [rmm_pkg::NW-1:0]       rem_out,
    output logic [rmm_pkg::NW-1:0]       q_out,
    output logic [rmm_pkg::DW-1:0]       den_out
);
    import rmm_pkg::*;

    localparam int SH = 63 - STAGE;

    logic [NW-1:0] rem_reg, q_reg, rem_next, q_next, dsh;
    logic [DW-1:0] den_reg;

    always_comb
    begin
        dsh = NW'(den_in) << SH;
        q_next = q_in;
        if (rem_in >= dsh)
        begin
            rem_next = rem_in - dsh;
            q_next[SH] = 1'b1;
        end
        else
        begin
            rem_next = rem_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_in;
    end

    assign rem_out = rem_reg;
    assign q_out   = q_reg;
    assign den_out = den_reg;
endmodule
`default_nettype wire
